// File: sv/pfc_pkg.sv
// Package for the pixel format converter: format codes, register map, gray weights, codecs.
package pfc_pkg;

  // Memory formats, densely numbered
  typedef enum logic [3:0] {
    FMT_ARGB8888 = 4'd0,
    FMT_ABGR8888 = 4'd1,
    FMT_RGBA8888 = 4'd2,
    FMT_BGRA8888 = 4'd3,
    FMT_RGB0888  = 4'd4,
    FMT_BGR0888  = 4'd5,
    FMT_RGB8880  = 4'd6,
    FMT_BGR8880  = 4'd7,
    FMT_RGB888   = 4'd8,
    FMT_BGR888   = 4'd9,
    FMT_RGB555BE = 4'd10,
    FMT_RGB555LE = 4'd11,
    FMT_RGB565BE = 4'd12,
    FMT_RGB565LE = 4'd13,
    FMT_BGR323I  = 4'd14,
    FMT_GRAY8    = 4'd15
  } fmt_t;

  // Register map (word index within the APB window)
  typedef enum logic {
    REG_SOURCE_FORMAT = 1'b0,
    REG_DEST_FORMAT   = 1'b1
  } reg_idx_t;

  localparam int unsigned PADDR_W = 3;

  // Luma weights, Q24
  localparam logic [23:0] GRAY_WR = 24'd5034375;
  localparam logic [23:0] GRAY_WG = 24'd9886846;
  localparam logic [23:0] GRAY_WB = 24'd1920103;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

  // Source word to ARGB8888
  function automatic logic [31:0] decode(input fmt_t fmt, input logic [31:0] w);
    logic [15:0] v;
    logic [7:0]  n;
    v = 16'h0;
    n = ~w[7:0];
    decode = w;
    unique case (fmt)
      FMT_ARGB8888: decode = w;
      FMT_ABGR8888: decode = {w[31:24], w[7:0], w[15:8], w[23:16]};
      FMT_RGBA8888: decode = {w[7:0], w[31:8]};
      FMT_BGRA8888: decode = {w[7:0], w[15:8], w[23:16], w[31:24]};
      FMT_RGB0888,
      FMT_RGB888:   decode = {ALPHA_OPAQUE, w[23:0]};
      FMT_BGR0888,
      FMT_BGR888:   decode = {ALPHA_OPAQUE, w[7:0], w[15:8], w[23:16]};
      FMT_RGB8880:  decode = {ALPHA_OPAQUE, w[31:8]};
      FMT_BGR8880:  decode = {ALPHA_OPAQUE, w[15:8], w[23:16], w[31:24]};
      FMT_RGB555BE,
      FMT_RGB555LE: begin
        v = (fmt == FMT_RGB555BE) ? w[15:0] : {w[7:0], w[15:8]};
        decode = {ALPHA_OPAQUE, v[14:10], 3'b0, v[9:5], 3'b0, v[4:0], 3'b0};
      end
      FMT_RGB565BE,
      FMT_RGB565LE: begin
        v = (fmt == FMT_RGB565BE) ? w[15:0] : {w[7:0], w[15:8]};
        decode = {ALPHA_OPAQUE, v[15:11], 3'b0, v[10:5], 2'b0, v[4:0], 3'b0};
      end
      FMT_BGR323I:  decode = {ALPHA_OPAQUE, n[7:5], 5'b0, n[4:3], 6'b0, n[2:0], 5'b0};
      FMT_GRAY8:    decode = {ALPHA_OPAQUE, w[7:0], w[7:0], w[7:0]};
      default:      decode = w;
    endcase
  endfunction

  // ARGB8888 to destination word; gray is the precomputed Q24 weighted sum
  function automatic logic [31:0] encode(input fmt_t fmt, input logic [31:0] p,
                                         input logic [31:0] gray_sum);
    logic [7:0]  al, r, g, b;
    logic [15:0] v;
    al = p[31:24];
    r  = p[23:16];
    g  = p[15:8];
    b  = p[7:0];
    v  = 16'h0;
    encode = p;
    unique case (fmt)
      FMT_ARGB8888: encode = p;
      FMT_ABGR8888: encode = {al, b, g, r};
      FMT_RGBA8888: encode = {r, g, b, al};
      FMT_BGRA8888: encode = {b, g, r, al};
      FMT_RGB0888:  encode = {8'h0, r, g, b};
      FMT_BGR0888:  encode = {8'h0, b, g, r};
      FMT_RGB8880:  encode = {r, g, b, 8'h0};
      FMT_BGR8880:  encode = {b, g, r, 8'h0};
      FMT_RGB888:   encode = {8'h0, r, g, b};
      FMT_BGR888:   encode = {8'h0, b, g, r};
      FMT_RGB555BE,
      FMT_RGB555LE: begin
        v = {1'b0, r[7:3], g[7:3], b[7:3]};
        encode = (fmt == FMT_RGB555BE) ? {16'h0, v} : {16'h0, v[7:0], v[15:8]};
      end
      FMT_RGB565BE,
      FMT_RGB565LE: begin
        v = {r[7:3], g[7:2], b[7:3]};
        encode = (fmt == FMT_RGB565BE) ? {16'h0, v} : {16'h0, v[7:0], v[15:8]};
      end
      FMT_BGR323I:  encode = {24'h0, ~{r[7:5], g[7:6], b[7:5]}};
      FMT_GRAY8:    encode = {24'h0, gray_sum[31:24]};
      default:      encode = p;
    endcase
  endfunction

  // Bytes per destination pixel
  function automatic logic [2:0] fmt_length(input fmt_t fmt);
    fmt_length = 3'd4;
    unique case (fmt)
      FMT_ARGB8888, FMT_ABGR8888, FMT_RGBA8888, FMT_BGRA8888,
      FMT_RGB0888, FMT_BGR0888, FMT_RGB8880, FMT_BGR8880: fmt_length = 3'd4;
      FMT_RGB888, FMT_BGR888:                             fmt_length = 3'd3;
      FMT_RGB555BE, FMT_RGB555LE,
      FMT_RGB565BE, FMT_RGB565LE:                         fmt_length = 3'd2;
      FMT_BGR323I, FMT_GRAY8:                             fmt_length = 3'd1;
      default:                                            fmt_length = 3'd4;
    endcase
  endfunction

endpackage

// File: sv/pfc_in_if.sv
// Input channel: one source pixel word per item.
interface pfc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_word;

  modport source (output valid, output source_word, input ready);
  modport sink   (input valid, input source_word, output ready);
endinterface

// File: sv/pfc_out_if.sv
// Output channel: converted pixel, its byte length and the decoded ARGB value.
interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dest_word;
  logic [2:0]  dest_length;
  logic [31:0] argb_value;

  modport source (output valid, output dest_word, output dest_length, output argb_value,
                  input ready);
  modport sink   (input valid, input dest_word, input dest_length, input argb_value,
                  output ready);
endinterface

// File: sv/pixel_format_converter_unit.sv
// Pixel format converter top level: decode to ARGB8888, encode to the destination format.
//
// Usage:
//  - src carries one source pixel word per item (bytes right-aligned, byte 0 most
//    significant); dst returns the destination word, its length in bytes and the
//    decoded ARGB8888 value, one result per item, in order.
//  - source_format (address 0) and dest_format (address 4) are set over the APB
//    port while the converter is idle; reads return the current values.
//  - Three register stages: decode into stage 1, gray products into stage 2,
//    encode into the output register. Throughput is one item per clock while
//    dst.ready stays high.
//  - The gray weights are three 8x24 multiplies, registered before the sum.
//  - Each stage loads when it is empty or its successor moves, so bubbles
//    close up and src.ready stays high while the output register holds a
//    result that dst has not yet taken, as long as an earlier stage is free.
//  - A stall on dst.ready holds the output register; once all stages are full
//    src.ready drops until dst takes the held result.
//  - Synchronous reset empties the pipeline and sets both formats to argb8888.
module pixel_format_converter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  pfc_in_if.sink                       src,
  pfc_out_if.source                    dst
);

  pfc_pkg::fmt_t source_format;
  pfc_pkg::fmt_t dest_format;
  logic          cfg_wr;
  pfc_pkg::reg_idx_t cfg_idx;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = pfc_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= pfc_pkg::FMT_ARGB8888;
      dest_format   <= pfc_pkg::FMT_ARGB8888;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pfc_pkg::REG_SOURCE_FORMAT: source_format <= pfc_pkg::fmt_t'(pwdata[3:0]);
        pfc_pkg::REG_DEST_FORMAT:   dest_format   <= pfc_pkg::fmt_t'(pwdata[3:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pfc_pkg::REG_SOURCE_FORMAT: prdata = {28'h0, source_format};
      pfc_pkg::REG_DEST_FORMAT:   prdata = {28'h0, dest_format};
      default:                    prdata = 32'h0;
    endcase
  end

  // Pipeline state
  logic        v1, v2, v3;
  logic        adv1, adv2, adv3;
  logic [31:0] argb1, argb2;
  logic [31:0] prod_r, prod_g, prod_b;
  logic [31:0] gray_sum;
  logic [31:0] dest_word;
  logic [2:0]  dest_length;
  logic [31:0] argb_value;

  // Stage enables: a stage loads when empty or when its successor moves
  assign adv3      = !v3 || dst.ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign src.ready = adv1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= src.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Stage 1: decode the source word
  always_ff @(posedge clk) begin
    if (adv1 && src.valid) begin
      argb1 <= pfc_pkg::decode(source_format, src.source_word);
    end
  end

  // Stage 2: weighted channel products for gray
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      argb2  <= argb1;
      prod_r <= {24'h0, argb1[23:16]} * {8'h0, pfc_pkg::GRAY_WR};
      prod_g <= {24'h0, argb1[15:8]}  * {8'h0, pfc_pkg::GRAY_WG};
      prod_b <= {24'h0, argb1[7:0]}   * {8'h0, pfc_pkg::GRAY_WB};
    end
  end

  // Stage 3: encode into the output register
  assign gray_sum = prod_r + prod_g + prod_b;

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      dest_word   <= pfc_pkg::encode(dest_format, argb2, gray_sum);
      dest_length <= pfc_pkg::fmt_length(dest_format);
      argb_value  <= argb2;
    end
  end

  assign dst.valid       = v3;
  assign dst.dest_word   = dest_word;
  assign dst.dest_length = dest_length;
  assign dst.argb_value  = argb_value;

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !dst.valid && !v1 && !v2)
    else $error("pipeline not empty after reset");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    dst.valid |-> (dest_length == 3'd1 || dest_length == 3'd2 ||
                   dest_length == 3'd3 || dest_length == 3'd4))
    else $error("destination length out of range");

  a_unused_bytes: assert property (@(posedge clk) disable iff (rst)
    dst.valid && dest_length == 3'd1 |-> dest_word[31:8] == 24'h0)
    else $error("unused destination bytes not zero");

  a_short_bytes: assert property (@(posedge clk) disable iff (rst)
    dst.valid && dest_length == 3'd2 |-> dest_word[31:16] == 16'h0)
    else $error("unused destination bytes not zero");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !adv2 |=> v1 && $stable(argb1))
    else $error("stage 1 item lost during stall");

endmodule
